/* src/wcp_pkg.sv */
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared constants and types for the wheel command parser.
// ----------------------------------------------------------------------------
package wcp_pkg;

	// Largest field magnitude; larger values saturate here.
	localparam int MAX_MAGNITUDE = 9999;
	localparam int MAG_W         = $clog2(MAX_MAGNITUDE + 1);
	// A magnitude times ten plus one digit fits in four more bits.
	localparam int PROD_W        = MAG_W + 4;
	localparam int DIGIT_W       = 4;
	localparam int BYTE_W        = 8;
	localparam int DUTY_W        = 8;
	localparam int CMD_W         = 2 * (DUTY_W + 1) + 1;
	localparam int OUT_TDATA_W   = ((CMD_W + 7) / 8) * 8;

	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// Which field of the message is being received.
	typedef enum logic [2:0] {
		FLD_LEFT  = 3'b001,
		FLD_RIGHT = 3'b010,
		FLD_EXTRA = 3'b100
	} field_t;

	// One finished wheel command, handed from the parser to the output stage.
	typedef struct packed {
		logic              overflowed;
		logic [DUTY_W-1:0] right_duty;
		logic              right_backward;
		logic [DUTY_W-1:0] left_duty;
		logic              left_backward;
	} wheel_cmd_t;

endpackage

/* src/wcp_parser.sv */
// ----------------------------------------------------------------------------
// wcp_parser
// Field state and the per-character update: sign, digit accumulation with
// saturation, field switching and the command built on the end mark.
// ----------------------------------------------------------------------------
module wcp_parser
	import wcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,   // consume rx_byte this cycle
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              emit,      // rx_byte ends a message
	output wheel_cmd_t        cmd
);

	logic [MAG_W-1:0]   acc_q;
	logic               neg_q;
	logic               started_q;   // at least one character in this field
	field_t             field_q;
	logic               left_neg_q;
	logic [MAG_W-1:0]   left_mag_q;
	logic               sat_seen_q;

	logic [DIGIT_W-1:0] digit;
	logic [PROD_W-1:0]  prod;
	logic               prod_sat;
	logic [MAG_W-1:0]   next_mag;
	logic               lneg;
	logic [MAG_W-1:0]   lmag;
	logic               rneg;
	logic [MAG_W-1:0]   rmag;

	assign emit = (rx_byte == CH_HASH);

	always_comb begin
		if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
			digit = DIGIT_W'(rx_byte - CH_ZERO);
		end else begin
			digit = '0;
		end
		prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + PROD_W'(digit);
		prod_sat = (prod > PROD_W'(MAX_MAGNITUDE));
		next_mag = prod_sat ? MAG_W'(MAX_MAGNITUDE) : prod[MAG_W-1:0];
	end

	// A message that never saw a comma has only a left field.
	always_comb begin
		if (field_q == FLD_LEFT) begin
			lneg = neg_q;
			lmag = acc_q;
			rneg = 1'b0;
			rmag = '0;
		end else begin
			lneg = left_neg_q;
			lmag = left_mag_q;
			rneg = neg_q;
			rmag = acc_q;
		end
		cmd.left_backward  = lneg && (lmag != '0);
		cmd.left_duty      = lmag[DUTY_W-1:0];
		cmd.right_backward = rneg && (rmag != '0);
		cmd.right_duty     = rmag[DUTY_W-1:0];
		cmd.overflowed     = sat_seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			neg_q      <= 1'b0;
			started_q  <= 1'b0;
			field_q    <= FLD_LEFT;
			left_neg_q <= 1'b0;
			left_mag_q <= '0;
			sat_seen_q <= 1'b0;
		end else if (advance) begin
			if (emit) begin
				acc_q      <= '0;
				neg_q      <= 1'b0;
				started_q  <= 1'b0;
				field_q    <= FLD_LEFT;
				left_neg_q <= 1'b0;
				left_mag_q <= '0;
				sat_seen_q <= 1'b0;
			end else if (field_q != FLD_EXTRA) begin
				if (rx_byte == CH_COMMA) begin
					if (field_q == FLD_LEFT) begin
						left_neg_q <= neg_q;
						left_mag_q <= acc_q;
						acc_q      <= '0;
						neg_q      <= 1'b0;
						started_q  <= 1'b0;
						field_q    <= FLD_RIGHT;
					end else begin
						field_q <= FLD_EXTRA;
					end
				end else begin
					started_q <= 1'b1;
					if (rx_byte == CH_MINUS && !started_q) begin
						neg_q <= 1'b1;
					end else begin
						acc_q <= next_mag;
						if (prod_sat) begin
							sat_seen_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	a_mag_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q <= MAG_W'(MAX_MAGNITUDE)) && (left_mag_q <= MAG_W'(MAX_MAGNITUDE)))
		else $error("field magnitude above saturation limit");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> (acc_q == '0) && !sat_seen_q && (field_q == FLD_LEFT))
		else $error("parser state not cleared after end of message");

endmodule

/* src/wcp_out_stage.sv */
// ----------------------------------------------------------------------------
// wcp_out_stage
// Result register for the master-side stream; holds one command until taken.
// ----------------------------------------------------------------------------
module wcp_out_stage
	import wcp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  wheel_cmd_t             cmd,
	output logic                   free,    // a new command may load this cycle
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic       valid_q;
	wheel_cmd_t cmd_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_TDATA_W'(cmd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd;
		end
	end

endmodule

/* src/wheel_command_parser.sv */
// ----------------------------------------------------------------------------
// wheel_command_parser
// Parses "left,right#" ASCII wheel commands into direction and duty per wheel.
// ----------------------------------------------------------------------------
// Each slave-side transaction carries one received character. The block
// registers it, updates the field state and, on '#', loads one
// wheel command into the output register. A leading '-' makes a field
// negative, every other character adds a decimal digit (non-digits count as
// zero), magnitudes saturate at 9999 and set the overflow bit of the message,
// a comma closes the left field and anything after a second comma is ignored
// until '#'. Duty is the low eight bits of the magnitude; a zero magnitude is
// always reported as forward. Throughput is one character per clock: the
// input register drains every cycle unless it holds a '#' while the output
// register still holds an untaken command. An accepted '#' passes the input
// register and then the output register before it reaches m_tvalid. Only the
// output register's ready path reaches s_tready combinationally.
module wheel_command_parser
	import wcp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Received characters: [7:0] rx_byte.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,
	// Wheel commands: [0] left_backward, [8:1] left_duty, [9] right_backward,
	// [17:10] right_duty, [18] overflowed, [23:19] zero.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic              in_valid_s1;
	logic [BYTE_W-1:0] in_byte_s1;
	logic              emit;
	logic              out_free;
	logic              advance;
	wheel_cmd_t        cmd;

	// The registered character moves on unless it ends a message and the
	// output register has no room for the command.
	assign advance  = in_valid_s1 && (!emit || out_free);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
	end

	wcp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (in_byte_s1),
		.emit    (emit),
		.cmd     (cmd)
	);

	wcp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.cmd      (cmd),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> m_tvalid)
		else $error("end of message did not produce a command");

	a_stall_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |-> emit && m_tvalid && !m_tready)
		else $error("input stage stalled without a blocked command");

endmodule

/* dv/wcp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_checker
// Watches both streams of the wheel command parser and checks every command.
// ----------------------------------------------------------------------------
// Each accepted character is run through a local copy of the field parser.
// Each '#' queues the wheel command that it should produce. Each accepted
// output transaction is compared field by field with the oldest queued one.
module wcp_checker
	import wcp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     mismatch_count,
	output int                     pending_cmds,
	output int                     cmds_checked,
	output int                     overflow_cmds
);

	wheel_cmd_t       expected_cmds[$];
	int               mismatches;
	int               checked;
	int               overflows;

	// Parser state for the message being received.
	logic [MAG_W-1:0] cur_mag;
	logic             cur_neg;
	logic [2:0]       cur_chars;
	field_t           cur_field;
	logic             left_neg;
	logic [MAG_W-1:0] left_mag;
	logic             sat_seen;

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatches++;
		$display("MISMATCH at %0t ns: %s, expected %0d, got %0d", $realtime, what, want, got);
	endtask

	function automatic void clear_field();
		cur_mag   = '0;
		cur_neg   = 1'b0;
		cur_chars = '0;
	endfunction

	function automatic void clear_message();
		clear_field();
		cur_field = FLD_LEFT;
		left_neg  = 1'b0;
		left_mag  = '0;
		sat_seen  = 1'b0;
	endfunction

	task automatic parse_char(input logic [BYTE_W-1:0] ch);
		wheel_cmd_t       cmd;
		logic [MAG_W-1:0] l_mag;
		logic [MAG_W-1:0] r_mag;
		logic             l_neg;
		logic             r_neg;
		int               digit;
		int               grown;
		if (ch == CH_HASH) begin
			if (cur_field == FLD_LEFT) begin
				l_neg = cur_neg;
				l_mag = cur_mag;
				r_neg = 1'b0;
				r_mag = '0;
			end else begin
				l_neg = left_neg;
				l_mag = left_mag;
				r_neg = cur_neg;
				r_mag = cur_mag;
			end
			// A zero magnitude always drives forward.
			cmd.left_backward  = l_neg && (l_mag != '0);
			cmd.left_duty      = l_mag[DUTY_W-1:0];
			cmd.right_backward = r_neg && (r_mag != '0);
			cmd.right_duty     = r_mag[DUTY_W-1:0];
			cmd.overflowed     = sat_seen;
			expected_cmds.push_back(cmd);
			if (sat_seen)
				overflows++;
			clear_message();
		end else if (cur_field != FLD_EXTRA) begin
			if (ch == CH_COMMA) begin
				if (cur_field == FLD_LEFT) begin
					left_neg  = cur_neg;
					left_mag  = cur_mag;
					clear_field();
					cur_field = FLD_RIGHT;
				end else begin
					cur_field = FLD_EXTRA;
				end
			end else begin
				if (ch == CH_MINUS && cur_chars == '0) begin
					cur_neg = 1'b1;
				end else begin
					digit = (ch >= CH_ZERO && ch <= CH_NINE) ? int'(ch - CH_ZERO) : 0;
					grown = int'(cur_mag) * 10 + digit;
					if (grown > MAX_MAGNITUDE) begin
						grown    = MAX_MAGNITUDE;
						sat_seen = 1'b1;
					end
					cur_mag = MAG_W'(grown);
				end
				if (cur_chars != 3'd7)
					cur_chars++;
			end
		end
	endtask

	task automatic check_cmd(input logic [OUT_TDATA_W-1:0] word);
		wheel_cmd_t got;
		wheel_cmd_t want;
		got = wheel_cmd_t'(word[CMD_W-1:0]);
		if (expected_cmds.size() == 0) begin
			report_mismatch("wheel command with none pending", 0, word);
			return;
		end
		want = expected_cmds.pop_front();
		checked++;
		if (got.left_backward != want.left_backward)
			report_mismatch("left_backward", want.left_backward, got.left_backward);
		if (got.left_duty != want.left_duty)
			report_mismatch("left_duty", want.left_duty, got.left_duty);
		if (got.right_backward != want.right_backward)
			report_mismatch("right_backward", want.right_backward, got.right_backward);
		if (got.right_duty != want.right_duty)
			report_mismatch("right_duty", want.right_duty, got.right_duty);
		if (got.overflowed != want.overflowed)
			report_mismatch("overflowed", want.overflowed, got.overflowed);
		if (word[OUT_TDATA_W-1:CMD_W] != '0)
			report_mismatch("tdata padding", 0, word[OUT_TDATA_W-1:CMD_W]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_cmds.delete();
			clear_message();
			mismatches = 0;
			checked    = 0;
			overflows  = 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_char(s_tdata);
			if (m_tvalid && m_tready)
				check_cmd(m_tdata);
		end
		mismatch_count <= mismatches;
		pending_cmds   <= expected_cmds.size();
		cmds_checked   <= checked;
		overflow_cmds  <= overflows;
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the wheel command parser.
// ----------------------------------------------------------------------------
// A short directed part walks through the corner cases of the command syntax:
// missing and empty fields, negative zero, a minus sign that is not leading,
// non-digit bytes, the exact maximum magnitude, saturation and fields past
// the second. Random messages follow, most of them well formed with random
// content, the rest noise. The sender and the receiver idle at random in
// three mixes. A separate checker predicts and compares every command.
module tb;
	import wcp_pkg::*;

	// Far above the slowest correct run, even with long output stalls.
	localparam int CYCLE_LIMIT  = 200000;
	// A '#' passes the input register and the output register before m_tvalid.
	localparam int SETTLE_WAIT  = 8;
	localparam int PHASE_CHARS  = 550;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int mismatch_count;
	int pending_cmds;
	int cmds_checked;
	int overflow_cmds;

	// Idle rates in percent of cycles, changed between traffic phases.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int chars_sent  = 0;
	int msgs_sent   = 0;
	int cycle_count = 0;

	always #6 clk = ~clk;

	wheel_command_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	wcp_checker cmd_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.pending_cmds   (pending_cmds),
		.cmds_checked   (cmds_checked),
		.overflow_cmds  (overflow_cmds)
	);

	// The receiver drops ready at random; a zero rate keeps it high.
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Hands one character to the block. Gaps come first, so that valid only
	// ever gets one assignment per clock edge. The transaction completes on
	// the first edge at which ready was seen high together with valid.
	task automatic send_char(input logic [BYTE_W-1:0] ch);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chars_sent++;
		if (ch == CH_HASH)
			msgs_sent++;
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_char(text[i]);
	endtask

	// One field: an optional sign, then up to six characters that are mostly
	// digits. Four digits reach the maximum magnitude and five always
	// saturate unless they start with zeros. Now and then a stray minus or a
	// random byte lands among the digits.
	task automatic send_field();
		int pick;
		int n_chars;
		if ($urandom_range(1))
			send_char(CH_MINUS);
		pick = $urandom_range(9);
		if (pick == 0)
			n_chars = 0;
		else if (pick == 9)
			n_chars = $urandom_range(5, 6);
		else
			n_chars = $urandom_range(1, 4);
		repeat (n_chars) begin
			pick = $urandom_range(19);
			if (pick == 0)
				send_char(8'($urandom_range(255)));
			else if (pick == 1)
				send_char(CH_MINUS);
			else
				send_char(8'(CH_ZERO + $urandom_range(9)));
		end
	endtask

	// Most messages are "left,right#". Some lack the comma, some carry
	// fields past the second, and some are plain noise closed by a '#'.
	task automatic send_message();
		int kind;
		kind = $urandom_range(99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 8))
				send_char(8'($urandom_range(255)));
		end else begin
			send_field();
			if (kind >= 20) begin
				send_char(CH_COMMA);
				send_field();
				if (kind >= 90) begin
					send_char(CH_COMMA);
					repeat ($urandom_range(0, 4))
						send_char(8'($urandom_range(255)));
				end
			end
		end
		send_char(CH_HASH);
	endtask

	// The sender holds back until every queued command has come out.
	task automatic wait_for_commands();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cmds != 0)
			@(posedge clk);
	endtask

	task automatic run_traffic(input int tx_pct, input int rx_pct, input int n_chars);
		int stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at     = chars_sent + n_chars;
		while (chars_sent < stop_at)
			send_message();
		wait_for_commands();
	endtask

	// Timeout: a hang anywhere ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d commands outstanding", cycle_count,
			pending_cmds);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 26;
		rx_idle_pct = 73;
		// Both fields missing.
		send_text("#");
		// Negative zero, once as a bare sign and once as "-0".
		send_text("-,-0#");
		// A minus that is not leading and a non-digit byte both count as zero,
		// giving 300 on the left; the right field lands exactly on the maximum
		// and must not raise the overflow bit.
		send_text("3-");
		send_char(8'hFF);
		send_text(",9999#");
		// A negative saturated left field, an empty right field, and a byte
		// of all zeros in a third field that must be ignored.
		send_text("-99999,,");
		send_char(8'h00);
		send_text("#");

		run_traffic(26, 73, PHASE_CHARS);
		run_traffic(73, 26, PHASE_CHARS);
		run_traffic(0, 0, PHASE_CHARS);

		repeat (SETTLE_WAIT) @(posedge clk);

		$display("Sent %0d characters in %0d messages: empty, missing, negative-zero,",
			chars_sent, msgs_sent);
		$display("noisy, saturated and extra fields; %0d commands checked, %0d overflowed.",
			cmds_checked, overflow_cmds);
		if (mismatch_count == 0 && pending_cmds == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
